[rtl/gribl_pkg.sv]
package gribl_pkg;

    localparam int DEF_MAX_DIM         = 4096;
    localparam int DEF_LANES           = 3;
    localparam int DEF_EXP_TABLE_DEPTH = 256;

    localparam int NUM_CH   = 3;
    localparam int COORD_W  = 12;
    localparam int DIM_W    = 13;
    localparam int SAMPLE_W = 8;
    localparam int K_W      = 32;
    localparam int CNT_W    = 2;
    localparam int W_W      = 17;
    localparam int W_ONE    = 65536;

    // weight pipeline depth ahead of the blend stage
    localparam int DLY = 6;

    localparam logic [63:0] EXP_LIMIT = 64'h1_0000_0000;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [DIM_W-1:0]   RST_WIDTH  = 13'd4096;
    localparam logic [DIM_W-1:0]   RST_HEIGHT = 13'd4096;
    localparam logic [COORD_W-1:0] RST_FIRST  = 12'd0;
    localparam logic [COORD_W-1:0] RST_LAST   = 12'd4095;
    localparam logic [K_W-1:0]     RST_K      = 32'h1000_0000;
    localparam logic [CNT_W-1:0]   RST_CHCNT  = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH     = 3'd0,
        REG_HEIGHT    = 3'd1,
        REG_COL_FIRST = 3'd2,
        REG_COL_LAST  = 3'd3,
        REG_ROW_FIRST = 3'd4,
        REG_ROW_LAST  = 3'd5,
        REG_K         = 3'd6,
        REG_CHCNT     = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [COORD_W-1:0] col_first;
        logic [COORD_W-1:0] col_last;
        logic [COORD_W-1:0] row_first;
        logic [COORD_W-1:0] row_last;
        logic [K_W-1:0]     k;
        logic [CNT_W-1:0]   chcnt;
    } t_cfg;

    typedef struct packed {
        logic           valid;
        logic           keep;
        logic [W_W-1:0] w;
    } t_wgt;

endpackage

[rtl/gaussian_radial_image_blend.sv]
// throughput: one item per cycle while the output spare register is empty, set by
// the single-pass weight pipeline (offset, square, sum, exponent multiply, table
// index, table read) and one blend per lane
// a two-entry output stage lets an item enter while a result waits downstream
// reset: synchronous, active low; clears all valid flags and loads register defaults
module gaussian_radial_image_blend import gribl_pkg::*; #(
    parameter int MAX_DIM         = DEF_MAX_DIM,
    parameter int LANES           = DEF_LANES,
    parameter int EXP_TABLE_DEPTH = DEF_EXP_TABLE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // col, row, first_ch0, first_ch1, first_ch2, second_ch0, second_ch1, second_ch2
    input  logic [71:0]           s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_ch0, out_ch1, out_ch2
    output logic [23:0]           m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg                r_cfg;
    logic                r_lv;
    logic                r_ov;
    logic [23:0]         r_od;
    logic                r_sv;
    logic [23:0]         r_sd;

    logic                en;
    logic                s_acc;
    logic                push;
    logic                pop;
    logic [2:0]          used;
    logic [NUM_CH-1:0]   lane_on;
    logic [SAMPLE_W-1:0] lane_out [NUM_CH];
    logic [23:0]         n_data;
    t_wgt                wgt;

    assign en            = !r_sv;
    assign s_axis_tready = en;
    assign s_acc         = s_axis_tvalid && en;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width     <= RST_WIDTH;
            r_cfg.height    <= RST_HEIGHT;
            r_cfg.col_first <= RST_FIRST;
            r_cfg.col_last  <= RST_LAST;
            r_cfg.row_first <= RST_FIRST;
            r_cfg.row_last  <= RST_LAST;
            r_cfg.k         <= RST_K;
            r_cfg.chcnt     <= RST_CHCNT;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_WIDTH:     r_cfg.width     <= i_cfg_data[DIM_W-1:0];
                REG_HEIGHT:    r_cfg.height    <= i_cfg_data[DIM_W-1:0];
                REG_COL_FIRST: r_cfg.col_first <= i_cfg_data[COORD_W-1:0];
                REG_COL_LAST:  r_cfg.col_last  <= i_cfg_data[COORD_W-1:0];
                REG_ROW_FIRST: r_cfg.row_first <= i_cfg_data[COORD_W-1:0];
                REG_ROW_LAST:  r_cfg.row_last  <= i_cfg_data[COORD_W-1:0];
                REG_K:         r_cfg.k         <= i_cfg_data[K_W-1:0];
                REG_CHCNT:     r_cfg.chcnt     <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    gribl_weight #(
        .MAX_DIM         (MAX_DIM),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_weight (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_acc),
        .i_col   (s_axis_tdata[11:0]),
        .i_row   (s_axis_tdata[23:12]),
        .i_cfg   (r_cfg),
        .o_wgt   (wgt)
    );

    assign used = (32'(r_cfg.chcnt) > LANES) ? 3'(LANES) : {1'b0, r_cfg.chcnt};

    for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
        assign lane_on[ch] = 3'(ch) < used;
        if (ch < LANES) begin : g_on
            gribl_lane u_lane (
                .i_clk    (i_clk),
                .i_en     (en),
                .i_on     (lane_on[ch]),
                .i_first  (s_axis_tdata[24 + SAMPLE_W*ch +: SAMPLE_W]),
                .i_second (s_axis_tdata[48 + SAMPLE_W*ch +: SAMPLE_W]),
                .i_wgt    (wgt),
                .o_out    (lane_out[ch])
            );
        end else begin : g_off
            assign lane_out[ch] = '0;
        end
    end

    // merge the lane results into one item
    assign n_data = {lane_out[2], lane_out[1], lane_out[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv <= 1'b0;
        end else if (en) begin
            r_lv <= wgt.valid;
        end
    end

    assign push = r_lv && en;
    assign pop  = r_ov && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_sv) begin
            if (!r_ov || pop) begin
                r_ov <= push;
            end else if (push) begin
                r_sv <= 1'b1;
            end
        end else if (pop) begin
            r_sv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_sv) begin
            if (!r_ov || pop) begin
                r_od <= n_data;
            end else if (push) begin
                r_sd <= n_data;
            end
        end else if (pop) begin
            r_od <= r_sd;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;

    a_spare_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("spare item held while output register empty");

    a_spare_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sv) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("spare register filled without an output stall");

    a_last_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lv && r_sv |=> r_lv)
        else $error("blend stage item lost while stalled");

endmodule

[rtl/gribl_weight.sv]
module gribl_weight import gribl_pkg::*; #(
    parameter int MAX_DIM         = DEF_MAX_DIM,
    parameter int EXP_TABLE_DEPTH = DEF_EXP_TABLE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [COORD_W-1:0] i_col,
    input  logic [COORD_W-1:0] i_row,
    input  t_cfg               i_cfg,
    output t_wgt               o_wgt
);

    localparam int IDX_W = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int SQ_W  = 2 * COORD_W;
    localparam int S_W   = SQ_W + 1;
    localparam int E_W   = S_W + K_W;
    localparam int P_W   = 33 + IDX_W;
    localparam int EXP_TERMS = 24;
    localparam logic [63:0] STEP = (64'd1 << 36) / 64'(EXP_TABLE_DEPTH);

    typedef logic [W_W-1:0] t_rom [EXP_TABLE_DEPTH+1];

    // exp(-step) from its series, in Q0.32
    function automatic logic [63:0] exp_base();
        logic [63:0] term;
        logic [63:0] base;
        term = 64'd1 << 32;
        base = term;
        for (int N = 1; N <= EXP_TERMS; N++) begin
            term = ((term * STEP) >> 32) / 64'(N);
            if (N % 2 == 1) begin
                base = base - term;
            end else begin
                base = base + term;
            end
        end
        return base;
    endfunction

    function automatic t_rom build_rom();
        logic [63:0] base;
        logic [63:0] acc;
        logic [63:0] rnd;
        t_rom        tab;
        base = exp_base();
        acc  = 64'd1 << 32;
        for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
            rnd    = (acc + 64'h8000) >> 16;
            tab[i] = (rnd > 64'(W_ONE)) ? W_W'(W_ONE) : W_W'(rnd);
            acc    = (acc * base) >> 32;
        end
        return tab;
    endfunction

    localparam t_rom ROM = build_rom();

    function automatic logic [COORD_W-1:0] centre(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] c;
        c = (32'(d) > MAX_DIM) ? DIM_W'(MAX_DIM) : d;
        return COORD_W'(c >> 1);
    endfunction

    function automatic logic [COORD_W-1:0] offset(input logic [COORD_W-1:0] p,
                                                  input logic [COORD_W-1:0] c);
        return (p >= c) ? (p - c) : (c - p);
    endfunction

    logic               r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic               r_k1, r_k2, r_k3, r_k4, r_k5, r_k6;
    logic [COORD_W-1:0] r_offx, r_offy;
    logic [SQ_W-1:0]    r_sqx, r_sqy;
    logic [S_W-1:0]     r_sum;
    logic [E_W-1:0]     r_exp;
    logic               r_zero;
    logic [IDX_W-1:0]   r_idx;
    logic [W_W-1:0]     r_w;

    logic               n_inside;
    logic               n_zero;
    logic [P_W-1:0]     n_prod;
    logic [IDX_W-1:0]   n_idx;

    assign n_inside = (i_col >= i_cfg.col_first) && (i_col <= i_cfg.col_last) &&
                      (i_row >= i_cfg.row_first) && (i_row <= i_cfg.row_last);

    // exponent above 16.0 gives a zero weight
    assign n_zero = r_exp > E_W'(EXP_LIMIT);
    assign n_prod = P_W'(r_exp[32:0]) * P_W'(EXP_TABLE_DEPTH);
    assign n_idx  = n_zero ? '0 : IDX_W'(n_prod >> 32);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_k1   <= n_inside;
            r_offx <= offset(i_col, centre(i_cfg.width));
            r_offy <= offset(i_row, centre(i_cfg.height));
            r_k2   <= r_k1;
            r_sqx  <= r_offx * r_offx;
            r_sqy  <= r_offy * r_offy;
            r_k3   <= r_k2;
            r_sum  <= S_W'(r_sqx) + S_W'(r_sqy);
            r_k4   <= r_k3;
            r_exp  <= E_W'(r_sum) * E_W'(i_cfg.k);
            r_k5   <= r_k4;
            r_zero <= n_zero;
            r_idx  <= n_idx;
            r_k6   <= r_k5;
            r_w    <= r_zero ? '0 : ROM[r_idx];
        end
    end

    assign o_wgt.valid = r_v6;
    assign o_wgt.keep  = r_k6;
    assign o_wgt.w     = r_w;

endmodule

[rtl/gribl_lane.sv]
module gribl_lane import gribl_pkg::*; (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic                i_on,
    input  logic [SAMPLE_W-1:0] i_first,
    input  logic [SAMPLE_W-1:0] i_second,
    input  t_wgt                i_wgt,
    output logic [SAMPLE_W-1:0] o_out
);

    logic [SAMPLE_W-1:0] r_first  [DLY];
    logic [SAMPLE_W-1:0] r_second [DLY];
    logic [SAMPLE_W-1:0] r_out;

    logic signed [W_W:0]      n_ws;
    logic signed [SAMPLE_W:0] n_diff;
    logic signed [26:0]       n_prod;
    logic signed [26:0]       n_sum;
    logic [SAMPLE_W-1:0]      n_out;

    // b*65536 + w*(a-b) equals w*a + (65536-w)*b
    assign n_ws   = signed'({1'b0, i_wgt.w});
    assign n_diff = signed'({1'b0, r_first[DLY-1]}) - signed'({1'b0, r_second[DLY-1]});
    assign n_prod = 27'(n_ws) * 27'(n_diff);
    assign n_sum  = signed'({3'b000, r_second[DLY-1], 16'h0000}) + n_prod;
    assign n_out  = (i_on && i_wgt.keep) ? n_sum[23:16] : '0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_first[0]  <= i_first;
            r_second[0] <= i_second;
            for (int i = 1; i < DLY; i++) begin
                r_first[i]  <= r_first[i-1];
                r_second[i] <= r_second[i-1];
            end
            r_out <= n_out;
        end
    end

    assign o_out = r_out;

endmodule
